[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the group reverse stream block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define GRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("grs assertion failed");

// Condition must never be true outside reset.
`define GRS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("grs forbidden condition seen");

`endif

[sv/grs_pkg.sv]
// ----------------------------------------------------------------------------
// grs_pkg
// Beat types and fixed constants of the group reverse stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

  localparam int WordWidth  = 16;
  localparam int GroupSizeW = 7;

  // Input beat
  typedef struct packed {
    logic [WordWidth-1:0] data_word;
    logic                 stream_end;
  } grs_in_t;

  // Output beat
  typedef struct packed {
    logic [WordWidth-1:0] out_word;
    logic                 run_last;
    logic                 stream_last;
  } grs_out_t;

  // Shift command broadcast to every cell of the chain
  typedef struct packed {
    logic up;    // cell i takes cell i-1, cell 0 takes the pushed word
    logic down;  // cell i takes cell i+1
  } grs_shift_t;

endpackage

`default_nettype wire

[sv/grs_cell.sv]
// ----------------------------------------------------------------------------
// grs_cell
// One storage cell of the word chain; loads from either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_cell
  import grs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire grs_shift_t           shift_i,
  input  wire logic [WordWidth-1:0] lo_i,
  input  wire logic [WordWidth-1:0] hi_i,
  output logic      [WordWidth-1:0] word_o
);

  logic [WordWidth-1:0] word_q;

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i.up) begin
      word_q <= lo_i;
    end else if (shift_i.down) begin
      word_q <= hi_i;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[sv/grs_chain.sv]
// ----------------------------------------------------------------------------
// grs_chain
// Bidirectional shift chain of word cells; pushes enter at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_chain
  import grs_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  wire logic                 clk_i,
  input  wire grs_shift_t           shift_i,
  input  wire logic [WordWidth-1:0] push_word_i,
  output logic      [WordWidth-1:0] bot_word_o,
  output logic      [WordWidth-1:0] top_word_o
);

  logic [WordWidth-1:0] cell_word [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [WordWidth-1:0] lo, hi;

    // Neighbor taps; the chain ends take the pushed word and zero
    if (g == 0) begin : g_lo_end
      assign lo = push_word_i;
    end else begin : g_lo_mid
      assign lo = cell_word[g-1];
    end
    if (g == Depth - 1) begin : g_hi_end
      assign hi = '0;
    end else begin : g_hi_mid
      assign hi = cell_word[g+1];
    end

    grs_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .lo_i    (lo),
      .hi_i    (hi),
      .word_o  (cell_word[g])
    );
  end

  assign bot_word_o = cell_word[0];
  assign top_word_o = cell_word[Depth-1];

endmodule

`default_nettype wire

[sv/group_reverse_stream_core.sv]
// Order: a beat that completes a group or ends the stream moves the sequencer
//   to its drain state, which loads the output register; results then leave
//   one per cycle unless out_ready_i stalls them. No input is taken during a
//   drain; a partial tail first shifts until its oldest word is in the top cell.
// Reset (rst_ni low, async): fill count cleared, group size back to 2,
//   output empty; the word chain itself is not reset.
// ----------------------------------------------------------------------------
// group_reverse_stream_core
// Collects words in a shift chain and emits full groups reversed, tails in order.
// ----------------------------------------------------------------------------
`default_nettype none

module group_reverse_stream_core
  import grs_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [GroupSizeW-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire grs_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output grs_out_t                   out_data_o
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int KW = (CW > GroupSizeW) ? CW : GroupSizeW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_REV   = 2'd1;
  localparam logic [1:0] S_ALIGN = 2'd2;
  localparam logic [1:0] S_FWD   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         align_q, align_d;
  logic                  end_q, end_d;
  logic [GroupSizeW-1:0] group_size_q;
  logic                  out_valid_q;
  grs_out_t              out_data_q;

  grs_shift_t            shift;
  logic [WordWidth-1:0]  bot_word, top_word;
  logic [CW-1:0]         fill_inc;
  logic [KW-1:0]         gs_ext, keff;
  logic                  full;
  logic                  out_load, load, src_top, run_last;

  // Word chain
  grs_chain #(
    .Depth (MAX_GROUP)
  ) u_chain (
    .clk_i       (clk_i),
    .shift_i     (shift),
    .push_word_i (in_data_i.data_word),
    .bot_word_o  (bot_word),
    .top_word_o  (top_word)
  );

  // Effective group size, clamped to 1..MAX_GROUP
  assign gs_ext   = KW'(group_size_q);
  assign keff     = (gs_ext == '0) ? KW'(1) :
                    (gs_ext > KW'(MAX_GROUP)) ? KW'(MAX_GROUP) : gs_ext;
  assign fill_inc = fill_q + CW'(1);
  assign full     = KW'(fill_inc) >= keff;
  assign out_load = !out_valid_q || out_ready_i;
  assign run_last = (cnt_q == CW'(1));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    align_d    = align_q;
    end_d      = end_q;
    shift      = '0;
    in_ready_o = 1'b0;
    load       = 1'b0;
    src_top    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          shift.up = 1'b1;
          if (full) begin
            state_d = S_REV;
            cnt_d   = fill_inc;
            end_d   = in_data_i.stream_end;
            fill_d  = '0;
          end else if (in_data_i.stream_end) begin
            cnt_d   = fill_inc;
            end_d   = 1'b1;
            fill_d  = '0;
            align_d = CW'(MAX_GROUP) - fill_inc;
            state_d = (align_d == '0) ? S_FWD : S_ALIGN;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      S_REV: begin
        if (out_load) begin
          load       = 1'b1;
          shift.down = 1'b1;
          cnt_d      = cnt_q - CW'(1);
          if (run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ALIGN: begin
        // move the oldest word up to the top cell
        shift.up = 1'b1;
        align_d  = align_q - CW'(1);
        if (align_q == CW'(1)) begin
          state_d = S_FWD;
        end
      end
      S_FWD: begin
        if (out_load) begin
          load     = 1'b1;
          src_top  = 1'b1;
          shift.up = 1'b1;
          cnt_d    = cnt_q - CW'(1);
          if (run_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      cnt_q        <= '0;
      align_q      <= '0;
      end_q        <= 1'b0;
      group_size_q <= GroupSizeW'(2);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      align_q <= align_d;
      end_q   <= end_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= load;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.out_word    <= src_top ? top_word : bot_word;
      out_data_q.run_last    <= run_last;
      out_data_q.stream_last <= run_last && end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `GRS_ASSERT(a_accept_moves, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> (fill_q != '0) || (state_q != S_IDLE))
  `GRS_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > CW'(MAX_GROUP))
  `GRS_ASSERT_NEVER(a_drain_count, clk_i, rst_ni,
    ((state_q == S_REV) || (state_q == S_FWD)) && (cnt_q == '0))
  `GRS_ASSERT(a_stream_last_run, clk_i, rst_ni,
    out_valid_o |-> (!out_data_o.stream_last || out_data_o.run_last))

endmodule

`default_nettype wire
